// File: hdl/assert_macros.svh
// Assertion macros for the checker file of this project.
// Depends on signals named clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ccbf_pkg.sv
// Package for the best-fit contiguous channel allocator.
// Holds sizes, item codes, the sequencer state type and shared structs.
`default_nettype none

package ccbf_pkg;

  localparam int CHANNELS = 10;
  localparam int TIME_W   = 32;
  localparam int WIDTH_W  = 4;
  localparam int INDEX_W  = 4;
  localparam int START_W  = 4;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LEN_W    = $clog2(CHANNELS + 1);
  localparam int CNT_W    = (LEN_W > WIDTH_W) ? LEN_W : WIDTH_W;

  localparam logic FUNC_CHECK = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE,
    ST_READ_LEFT,
    ST_READ_RIGHT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               func;
    logic [TIME_W-1:0]  arrive;
    logic [WIDTH_W-1:0] width;
    logic [INDEX_W-1:0] index;
    logic [TIME_W-1:0]  value;
  } item_t;

  typedef struct packed {
    logic              en;
    logic [CH_W-1:0]   addr;
    logic [TIME_W-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic            found;
    logic [CH_W-1:0] start;
  } res_t;

endpackage

`default_nettype wire

// File: hdl/contiguous_channel_best_fit.sv
// Best-fit contiguous channel allocator.
// Input channel: in_valid/in_ready with in_func selecting a check (find a
//   placement of in_req_width adjacent channels free at in_arrive_time) or a
//   write (set the release time of channel in_chan_index to in_release_value).
// Result channel: out_valid/out_ready with out_found and out_start_channel;
//   every input transaction yields exactly one result, writes give found = 0.
// Flow: a write or a zero-width check goes straight to the result. A check
//   scans one channel per cycle through the single release-time read port
//   and one 32-bit comparator, then resolves the placement, reading the left
//   and right neighbors when the two run neighbors must be compared. One
//   transaction is in flight at a time; in_ready returns the cycle after the
//   result moves to the output register, so a new transaction is taken only
//   once the last one has handed over its result.
// Reset: rst_n is synchronous, active low; all release times read as zero.
// Stall: the output register holds the result while out_ready is low; the
//   next transaction is taken and worked on meanwhile, and its result waits
//   inside until the output register frees up.
// Uses ccbf_pkg, ccbf_ctrl and ccbf_rel_mem.
`default_nettype none

module contiguous_channel_best_fit import ccbf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_func,
  input  wire logic [TIME_W-1:0]  in_arrive_time,
  input  wire logic [WIDTH_W-1:0] in_req_width,
  input  wire logic [INDEX_W-1:0] in_chan_index,
  input  wire logic [TIME_W-1:0]  in_release_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_found,
  output logic      [START_W-1:0] out_start_channel
);

  item_t             item;
  wr_req_t           wr;
  logic [CH_W-1:0]   rd_addr;
  logic [TIME_W-1:0] rd_data;
  logic              res_valid;
  logic              res_take;
  res_t              res;

  logic               out_valid_r;
  logic               out_found_r;
  logic [START_W-1:0] out_start_r;

  assign item.func   = in_func;
  assign item.arrive = in_arrive_time;
  assign item.width  = in_req_width;
  assign item.index  = in_chan_index;
  assign item.value  = in_release_value;

  ccbf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid),
    .item_ready (in_ready),
    .item       (item),
    .wr         (wr),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

  ccbf_rel_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Move the result into the output register when it is empty or draining
  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_found_r <= res.found;
      out_start_r <= START_W'(res.start);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_start_channel = out_start_r;

endmodule

`default_nettype wire

// File: hdl/ccbf_rel_mem.sv
// Release time store: one write port, one registered read port.
// Entries never written read as zero through per-entry valid bits. Uses ccbf_pkg.
`default_nettype none

module ccbf_rel_mem import ccbf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire wr_req_t           wr,
  input  wire logic [CH_W-1:0]   rd_addr,
  output logic      [TIME_W-1:0] rd_data
);

  logic [TIME_W-1:0]   mem_r [CHANNELS];
  logic [CHANNELS-1:0] vld_r;
  logic [TIME_W-1:0]   rd_data_r;
  logic                rd_ok;

  assign rd_ok   = (32'(rd_addr) < CHANNELS);
  assign rd_data = rd_data_r;

  // Mark written entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  // Store write data
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  // Register read data, zero for unwritten entries
  always_ff @(posedge clk) begin
    if (rd_ok && vld_r[rd_addr]) begin
      rd_data_r <= mem_r[rd_addr];
    end else begin
      rd_data_r <= '0;
    end
  end

endmodule

`default_nettype wire

// File: hdl/ccbf_ctrl.sv
// Sequencer for the allocator: scans channels one per cycle through a shared
// 32-bit comparator, tracks the best free run and resolves placement. Uses ccbf_pkg.
`default_nettype none

module ccbf_ctrl import ccbf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire item_t             item,
  output wr_req_t                wr,
  output logic      [CH_W-1:0]   rd_addr,
  input  wire logic [TIME_W-1:0] rd_data,
  output logic                   res_valid,
  input  wire logic              res_take,
  output res_t                   res
);

  state_t state_r, state_nxt;

  logic [TIME_W-1:0] arrive_r;
  logic [TIME_W-1:0] left_r;
  logic [CNT_W-1:0]  width_r;
  logic [CH_W-1:0]   scan_r;
  logic              run_act_r;
  logic [CH_W-1:0]   run_start_r;
  logic              best_vld_r;
  logic [CH_W-1:0]   best_start_r;
  logic [CH_W-1:0]   best_end_r;
  logic [CNT_W-1:0]  best_len_r;
  logic              res_found_r;
  logic [CH_W-1:0]   res_start_r;

  logic              accept;
  logic              quick;
  logic [TIME_W-1:0] cmp_b;
  logic              cmp_le;
  logic              is_free;
  logic              in_run;
  logic              last;
  logic              run_close;
  logic [CH_W-1:0]   start_eff;
  logic [CH_W-1:0]   end_idx;
  logic [CNT_W-1:0]  run_len;
  logic              take;
  logic              needs_nb;
  logic [CH_W-1:0]   direct_start;
  logic [CH_W-1:0]   packed_start;

  assign accept = item_valid && item_ready;
  assign quick  = (item.func == FUNC_WRITE) || (item.width == '0);

  // Shared comparator: channel against arrival while scanning,
  // right neighbor against left neighbor while resolving
  assign cmp_b  = (state_r == ST_SCAN) ? arrive_r : left_r;
  assign cmp_le = (rd_data <= cmp_b);

  // Run tracking for the channel whose read data is present
  assign is_free   = cmp_le;
  assign in_run    = run_act_r || is_free;
  assign last      = (scan_r == CH_W'(CHANNELS - 1));
  assign run_close = in_run && (!is_free || last);
  assign start_eff = run_act_r ? run_start_r : scan_r;
  assign end_idx   = is_free ? scan_r : scan_r - 1'b1;
  assign run_len   = CNT_W'(end_idx) - CNT_W'(start_eff) + 1'b1;
  assign take      = run_close && (run_len >= width_r) &&
                     (!best_vld_r || (run_len < best_len_r));

  // Placement inside the chosen run
  assign needs_nb = best_vld_r && (best_len_r != width_r) && (best_start_r != '0) &&
                    (best_end_r != CH_W'(CHANNELS - 1));
  assign packed_start = CH_W'(CNT_W'(best_end_r) + 1'b1 - width_r);
  always_comb begin
    if (best_len_r == width_r) begin
      direct_start = best_start_r;
    end else if (best_start_r == '0) begin
      direct_start = '0;
    end else begin
      direct_start = CH_W'(CNT_W'(CHANNELS) - width_r);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = quick ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last) begin
          state_nxt = ST_RESOLVE;
        end
      end
      ST_RESOLVE:    state_nxt = needs_nb ? ST_READ_LEFT : ST_DONE;
      ST_READ_LEFT:  state_nxt = ST_READ_RIGHT;
      ST_READ_RIGHT: state_nxt = ST_DONE;
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // Outputs per state
  always_comb begin
    item_ready = 1'b0;
    res_valid  = 1'b0;
    rd_addr    = '0;
    case (state_r)
      ST_IDLE:       item_ready = 1'b1;
      ST_SCAN:       rd_addr    = scan_r + 1'b1;
      ST_RESOLVE:    rd_addr    = best_start_r - 1'b1;
      ST_READ_LEFT:  rd_addr    = best_end_r + 1'b1;
      ST_READ_RIGHT: rd_addr    = '0;
      ST_DONE:       res_valid  = 1'b1;
      default:       rd_addr    = '0;
    endcase
  end

  // Write a release time straight from the accepted transaction
  assign wr.en   = accept && (item.func == FUNC_WRITE) && (32'(item.index) < CHANNELS);
  assign wr.addr = CH_W'(item.index);
  assign wr.data = item.value;

  assign res.found = res_found_r;
  assign res.start = res_start_r;

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Run and best-run control bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_act_r  <= 1'b0;
      best_vld_r <= 1'b0;
    end else if (accept) begin
      run_act_r  <= 1'b0;
      best_vld_r <= 1'b0;
    end else if (state_r == ST_SCAN) begin
      run_act_r <= in_run && !run_close;
      if (take) begin
        best_vld_r <= 1'b1;
      end
    end
  end

  // Scan datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      arrive_r <= item.arrive;
      width_r  <= CNT_W'(item.width);
      scan_r   <= '0;
    end else if (state_r == ST_SCAN) begin
      scan_r <= scan_r + 1'b1;
      if (!run_act_r && is_free) begin
        run_start_r <= scan_r;
      end
      if (take) begin
        best_start_r <= start_eff;
        best_end_r   <= end_idx;
        best_len_r   <= run_len;
      end
    end
  end

  // Result and neighbor capture
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_found_r <= 1'b0;
          res_start_r <= '0;
        end
      end
      ST_RESOLVE: begin
        if (!needs_nb) begin
          res_found_r <= best_vld_r;
          res_start_r <= best_vld_r ? direct_start : '0;
        end
      end
      ST_READ_LEFT: left_r <= rd_data;
      ST_READ_RIGHT: begin
        res_found_r <= 1'b1;
        res_start_r <= cmp_le ? best_start_r : packed_start;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/ccbf_checker.sv
// Port-level checker for the allocator, bound to the top level.
// Uses ccbf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ccbf_checker import ccbf_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               out_found,
  input wire logic [START_W-1:0] out_start_channel
);

  // A stalled result holds
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_found) && $stable(out_start_channel), "stalled result changed")

  // No placement reports start zero
  `ASSERT_NOW(a_miss_zero, out_valid && !out_found, out_start_channel == '0, "miss with nonzero start")

  // A placement starts on an existing channel
  `ASSERT_NOW(a_start_range, out_valid && out_found, (CHANNELS > 16) || (32'(out_start_channel) < CHANNELS), "start beyond channels")

  // One transaction in flight: busy right after acceptance
  `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready right after accept")

endmodule

bind contiguous_channel_best_fit ccbf_checker u_ccbf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_found         (out_found),
  .out_start_channel (out_start_channel)
);

`default_nettype wire
